// ===== rtl/prt_pkg.sv =====
package prt_pkg;

  // unity in the Q15 trig format
  localparam logic [16:0] TRIG_ONE = 17'd32768;

  // pi/180 scaled by 2^24
  localparam logic [18:0] DEG_RAD_Q24 = 19'd292818;

  // number of entries in each trig table
  localparam int unsigned TAB_DEPTH = 10;

  // largest table index
  localparam logic [3:0] TAB_LAST = 4'd9;

  // sin(10k deg), rounded Q15
  function automatic logic [15:0] sin10_q15(input logic [3:0] idx);
    logic [15:0] val;
    case (idx)
      4'd0: val = 16'd0;
      4'd1: val = 16'd5690;
      4'd2: val = 16'd11207;
      4'd3: val = 16'd16384;
      4'd4: val = 16'd21063;
      4'd5: val = 16'd25102;
      4'd6: val = 16'd28378;
      4'd7: val = 16'd30792;
      4'd8: val = 16'd32270;
      4'd9: val = 16'd32768;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

  // cos(k deg), rounded Q15
  function automatic logic [15:0] cos1_q15(input logic [3:0] idx);
    logic [15:0] val;
    case (idx)
      4'd0: val = 16'd32768;
      4'd1: val = 16'd32763;
      4'd2: val = 16'd32748;
      4'd3: val = 16'd32723;
      4'd4: val = 16'd32688;
      4'd5: val = 16'd32643;
      4'd6: val = 16'd32588;
      4'd7: val = 16'd32524;
      4'd8: val = 16'd32449;
      4'd9: val = 16'd32365;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/prt_sine.sv =====
module prt_sine #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic [2:0]            ld_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output logic signed [16:0]    sine_o
);
  import prt_pkg::*;

  localparam int unsigned TW = ANGLE_BITS + 8;
  localparam int unsigned RW = ANGLE_BITS + 4;
  localparam int unsigned MW = RW + 16;
  localparam int unsigned LW = MW + 19;
  localparam logic [TW-1:0] HALF    = TW'(1) << (ANGLE_BITS - 1);
  localparam logic [TW-1:0] QUARTER = TW'(1) << (ANGLE_BITS - 2);

  // stage 1: quadrant fold and split into 10-degree step and remainder
  logic          neg1_d, neg1_q;
  logic [3:0]    a1_d, a1_q;
  logic [3:0]    b1_d, b1_q;
  logic [RW-1:0] rem1_d, rem1_q;
  logic [TW-1:0] f_w, t_w, t36_w, t360_w, a10_w, rem_w;
  logic [TW-ANGLE_BITS-1:0] a_full, b_full;

  always_comb begin
    neg1_d = angle_i[ANGLE_BITS-1];
    f_w    = TW'(angle_i[ANGLE_BITS-2:0]);
    t_w    = (f_w > QUARTER) ? (HALF - f_w) : f_w;
    t36_w  = t_w * TW'(36);
    a_full = t36_w[TW-1:ANGLE_BITS];
    a1_d   = (a_full > (TW-ANGLE_BITS)'(TAB_LAST)) ? TAB_LAST : a_full[3:0];
    t360_w = t_w * TW'(360);
    a10_w  = (TW'(a1_d) * TW'(10)) << ANGLE_BITS;
    rem_w  = t360_w - a10_w;
    rem1_d = rem_w[RW-1:0];
    b_full = rem_w[TW-1:ANGLE_BITS];
    b1_d   = (b_full > (TW-ANGLE_BITS)'(TAB_LAST)) ? TAB_LAST : b_full[3:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      neg1_q <= neg1_d;
      a1_q   <= a1_d;
      b1_q   <= b1_d;
      rem1_q <= rem1_d;
    end
  end

  // stage 2: table product and remainder times the complementary sine
  logic          neg2_q;
  logic [16:0]   prod2_d, prod2_q;
  logic [MW-1:0] mr2_d, mr2_q;
  logic [31:0]   prod_w;

  always_comb begin
    prod_w  = 32'(sin10_q15(a1_q)) * 32'(cos1_q15(b1_q));
    prod2_d = prod_w[31:15];
    mr2_d   = MW'(rem1_q) * MW'(sin10_q15(TAB_LAST - a1_q));
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      neg2_q  <= neg1_q;
      prod2_q <= prod2_d;
      mr2_q   <= mr2_d;
    end
  end

  // stage 3: small-angle term, saturation at one and sign
  logic [LW-1:0]      lin_w;
  logic [16:0]        mag_w;
  logic signed [16:0] sine_d, sine_q;

  always_comb begin
    lin_w  = (LW'(mr2_q) * LW'(DEG_RAD_Q24)) >> (ANGLE_BITS + 24);
    mag_w  = prod2_q + lin_w[16:0];
    if (mag_w > TRIG_ONE) begin
      mag_w = TRIG_ONE;
    end
    sine_d = neg2_q ? -$signed(mag_w) : $signed(mag_w);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      sine_q <= sine_d;
    end
  end

  assign sine_o = sine_q;

endmodule

// ===== rtl/prt_rotate.sv =====
module prt_rotate #(
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                       clk_i,
  input  logic [1:0]                 ld_i,
  input  logic                       opcode_i,
  input  logic signed [16:0]         sine_i,
  input  logic signed [16:0]         cosine_i,
  input  logic signed [DATA_BITS-1:0] x_i,
  input  logic signed [DATA_BITS-1:0] y_i,
  output logic signed [DATA_BITS:0]  first_o,
  output logic signed [DATA_BITS:0]  second_o
);
  import prt_pkg::*;

  localparam int unsigned PW = DATA_BITS + 17;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned HW = SW - 15;
  localparam int unsigned OW = DATA_BITS + 1;

  // stage 4: the four products
  logic                 op_q;
  logic signed [PW-1:0] cx_q, sy_q, cy_q, sx_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      op_q <= opcode_i;
      cx_q <= PW'(cosine_i) * PW'(x_i);
      sy_q <= PW'(sine_i) * PW'(y_i);
      cy_q <= PW'(cosine_i) * PW'(y_i);
      sx_q <= PW'(sine_i) * PW'(x_i);
    end
  end

  // floor shift by 15, then clamp to the output range
  function automatic logic signed [OW-1:0] shift_sat(input logic signed [SW-1:0] v);
    logic signed [HW-1:0] h;
    logic signed [OW-1:0] r;
    h = $signed(v[SW-1:15]);
    if ((h[HW-1:OW-1] == '0) || (h[HW-1:OW-1] == '1)) begin
      r = h[OW-1:0];
    end else if (h[HW-1]) begin
      r = {1'b1, {(OW-1){1'b0}}};
    end else begin
      r = {1'b0, {(OW-1){1'b1}}};
    end
    return r;
  endfunction

  // stage 5: sums with opcode-selected signs, output register
  logic signed [SW-1:0] f_w, g_w;
  logic signed [OW-1:0] first_q, second_q;

  always_comb begin
    if (op_q) begin
      f_w = SW'(cx_q) - SW'(sy_q);
      g_w = SW'(sx_q) + SW'(cy_q);
    end else begin
      f_w = SW'(cx_q) + SW'(sy_q);
      g_w = SW'(cy_q) - SW'(sx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      first_q  <= shift_sat(f_w);
      second_q <= shift_sat(g_w);
    end
  end

  assign first_o  = first_q;
  assign second_o = second_q;

endmodule

// ===== rtl/park_rotation_table_trig.sv =====
// Park / inverse Park rotation with table-driven sine and cosine.
// Throughput: one request per cycle; each of the five stages holds its
// item under stall and moves up as soon as the stage ahead frees.
// Reset clears only the stage valid bits; the data registers are not reset.
module park_rotation_table_trig #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned DATA_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [ANGLE_BITS-1:0]       angle_i,
  input  logic signed [DATA_BITS-1:0] first_in_i,
  input  logic signed [DATA_BITS-1:0] second_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [DATA_BITS:0]   first_out_o,
  output logic signed [DATA_BITS:0]   second_out_o
);
  import prt_pkg::*;

  localparam int unsigned NSTG = 5;
  localparam logic [ANGLE_BITS-1:0] QUARTER_A = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  // stage valid bits and per-stage load enables
  logic [NSTG-1:0] vld_q, vld_d, ld;

  always_comb begin
    ld[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
    vld_d = vld_q;
    if (ld[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ld[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = vld_q[NSTG-1];

  // operands travel alongside the trig stages
  logic                        op_q [3];
  logic signed [DATA_BITS-1:0] x_q  [3];
  logic signed [DATA_BITS-1:0] y_q  [3];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      op_q[0] <= opcode_i;
      x_q[0]  <= first_in_i;
      y_q[0]  <= second_in_i;
    end
    for (int k = 1; k < 3; k++) begin
      if (ld[k]) begin
        op_q[k] <= op_q[k-1];
        x_q[k]  <= x_q[k-1];
        y_q[k]  <= y_q[k-1];
      end
    end
  end

  // sine and cosine units, cosine a quarter turn ahead
  logic [ANGLE_BITS-1:0] cos_angle;
  logic signed [16:0]    sine, cosine;

  assign cos_angle = angle_i + QUARTER_A;

  prt_sine #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_sine (
    .clk_i  (clk_i),
    .ld_i   (ld[2:0]),
    .angle_i(angle_i),
    .sine_o (sine)
  );

  prt_sine #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_cosine (
    .clk_i  (clk_i),
    .ld_i   (ld[2:0]),
    .angle_i(cos_angle),
    .sine_o (cosine)
  );

  // rotation products and output saturation
  prt_rotate #(
    .DATA_BITS(DATA_BITS)
  ) u_rotate (
    .clk_i   (clk_i),
    .ld_i    (ld[4:3]),
    .opcode_i(op_q[2]),
    .sine_i  (sine),
    .cosine_i(cosine),
    .x_i     (x_q[2]),
    .y_i     (y_q[2]),
    .first_o (first_out_o),
    .second_o(second_out_o)
  );

endmodule
